>>> hw/rtl/swa_pkg.sv
// swa_pkg: shared types and constants of the sliding window average block
// holds status and action codes, controller states and default sizes
// no dependencies
`default_nettype none

package swa_pkg;

	// default sizes of the sample store and of one sample value
	localparam int MAX_WINDOW_DEF = 1024;
	localparam int VALUE_BITS_DEF = 48;

	// fixed field widths
	localparam int ACTION_BITS = 3;
	localparam int QWIN_BITS   = 11;
	localparam int CFG_BITS    = 11;
	localparam int STATUS_BITS = 2;

	// window length after reset, before clamping to the store depth
	localparam int WINDOW_RESET = 60;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_INITIALIZED   = 2'd0,
		ST_NEEDS_SECOND  = 2'd1,
		ST_ACTIVE        = 2'd2,
		ST_NOT_SUPPORTED = 2'd3
	} status_t;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_GOOD_SAMPLE = 3'd0,
		ACT_NEEDS_SECOND = 3'd1,
		ACT_FAILED      = 3'd2,
		ACT_REATTACH    = 3'd3,
		ACT_QUERY       = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_SAMPLE,
		FS_WALK,
		FS_DIV,
		FS_FINISH
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/sliding_window_average.sv
// sliding_window_average: running average of one sampled counter over a circular store
// depends on swa_pkg for codes, states and default sizes
// contains the sample memory, the controller and a bit-serial divider
//
// channel   dir  payload (low bit first)                          transfer when
// s_*       in   action, sample_value, query_window               s_tvalid & s_tready
// m_*       out  average, status, answered                        m_tvalid & m_tready
// cfg_*     in   window_length                                    cfg_wr_en
//
// one item at a time; status-only actions go straight from idle to finish, a good
// sample passes through the sample write, a full-window query through the divider,
// and a query over the newest n samples first walks the store through its single
// read port, then goes through the one-bit-per-cycle divider
// reset clears status, fill count and sum and sets the window length to 60; the store
// is not cleared, the fill count keeps reads inside written slots
// a stalled output only holds the result register; the next item is still taken
`default_nettype none

module sliding_window_average
	import swa_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int IN_W      = ((ACTION_BITS + VALUE_BITS + QWIN_BITS + 7) / 8) * 8,
	localparam int OUT_W     = ((VALUE_BITS + STATUS_BITS + 1 + 7) / 8) * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// action, sample_value, query_window
	input  wire logic [IN_W-1:0]      s_tdata,
	// output stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// average, status, answered
	output logic [OUT_W-1:0]          m_tdata,
	// window length register
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_BITS-1:0]  cfg_wr_data
);

	localparam int ADDR_BITS = $clog2(MAX_WINDOW);
	localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_BITS  = VALUE_BITS + $clog2(MAX_WINDOW);
	localparam int CMP_W     = (WIN_BITS > CFG_BITS) ? WIN_BITS : CFG_BITS;
	localparam int DCNT_W    = $clog2(SUM_BITS + 1);
	localparam int WIN_RST   = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

	// input fields
	logic [ACTION_BITS-1:0] in_action;
	logic [VALUE_BITS-1:0]  in_value;
	logic [QWIN_BITS-1:0]   in_qwin;

	assign in_action = s_tdata[ACTION_BITS-1:0];
	assign in_value  = s_tdata[ACTION_BITS +: VALUE_BITS];
	assign in_qwin   = s_tdata[ACTION_BITS + VALUE_BITS +: QWIN_BITS];

	// controller and counter state
	state_t                state_q, state_nx;
	status_t               status_q;
	logic [WIN_BITS-1:0]   window_q;
	logic [WIN_BITS-1:0]   fill_q;
	logic [ADDR_BITS-1:0]  newest_q;
	logic                  newest_vld_q;
	logic signed [SUM_BITS-1:0] sum_q;

	// item being worked on
	logic [ADDR_BITS-1:0]  slot_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  ans_q;

	// walk over the store
	logic [WIN_BITS-1:0]   issue_left_q;
	logic [ADDR_BITS-1:0]  walk_addr_q;
	logic signed [SUM_BITS-1:0] acc_q;
	logic                  rd_vld_s1;
	logic [WIN_BITS-1:0]   walk_count_q;

	// divider
	logic [SUM_BITS-1:0]   dvd_q;
	logic [WIN_BITS-1:0]   dvs_q;
	logic [WIN_BITS-1:0]   rem_q;
	logic [DCNT_W-1:0]     div_cnt_q;
	logic                  neg_q;

	// output register
	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;

	// memory interface
	logic [VALUE_BITS-1:0] mem [MAX_WINDOW];
	logic [VALUE_BITS-1:0] rd_data_s1;
	logic                  rd_en;
	logic [ADDR_BITS-1:0]  rd_addr;
	logic                  mem_we;

	// decode helpers
	logic                  accept;
	logic                  supported;
	logic                  is_good;
	logic [ADDR_BITS-1:0]  next_slot;
	logic [WIN_BITS-1:0]   newest_inc;
	logic                  qwin_zero;
	logic                  qwin_bad;
	logic [WIN_BITS-1:0]   walk_count;
	logic                  query_walk;
	logic                  query_full;
	logic                  div_last;
	logic                  out_free;
	logic [WIN_BITS-1:0]   cfg_clamped;

	assign accept    = s_tvalid && s_tready;
	assign supported = (status_q != ST_NOT_SUPPORTED);
	assign is_good   = (action_t'(in_action) == ACT_GOOD_SAMPLE) && supported;
	assign out_free  = !m_tvalid_q || m_tready;
	assign div_last  = (div_cnt_q == DCNT_W'(1));

	// next slot to write, the oldest once the window is full, wrapping at the window length
	assign newest_inc = WIN_BITS'(newest_q) + WIN_BITS'(1);
	always_comb begin
		if (!newest_vld_q || newest_inc == window_q) begin
			next_slot = '0;
		end else begin
			next_slot = ADDR_BITS'(newest_inc);
		end
	end

	// query decode: out of range, full window, or walk over the newest n
	assign qwin_zero = (in_qwin == '0);
	assign qwin_bad  = (status_q != ST_ACTIVE) || (CMP_W'(in_qwin) > CMP_W'(window_q));
	always_comb begin
		if (CMP_W'(fill_q) < CMP_W'(in_qwin)) begin
			walk_count = fill_q;
		end else begin
			walk_count = WIN_BITS'(in_qwin);
		end
	end
	assign query_full = !qwin_bad && qwin_zero && (fill_q != '0);
	assign query_walk = !qwin_bad && !qwin_zero && (walk_count != '0);

	// window register write, zero taken as one and clamped to the store depth
	always_comb begin
		if (cfg_wr_data == '0) begin
			cfg_clamped = WIN_BITS'(1);
		end else if (CMP_W'(cfg_wr_data) > CMP_W'(MAX_WINDOW)) begin
			cfg_clamped = WIN_BITS'(MAX_WINDOW);
		end else begin
			cfg_clamped = WIN_BITS'(cfg_wr_data);
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			FS_IDLE: begin
				if (accept) begin
					if (action_t'(in_action) == ACT_QUERY) begin
						if (query_full) begin
							state_nx = FS_DIV;
						end else if (query_walk) begin
							state_nx = FS_WALK;
						end else begin
							state_nx = FS_FINISH;
						end
					end else if (is_good) begin
						state_nx = FS_SAMPLE;
					end else begin
						state_nx = FS_FINISH;
					end
				end
			end
			FS_SAMPLE: state_nx = FS_FINISH;
			FS_WALK: begin
				if (issue_left_q == '0 && !rd_vld_s1) begin
					state_nx = FS_DIV;
				end
			end
			FS_DIV: begin
				if (div_last) begin
					state_nx = FS_FINISH;
				end
			end
			FS_FINISH: begin
				if (out_free) begin
					state_nx = FS_IDLE;
				end
			end
			default: state_nx = FS_IDLE;
		endcase
	end

	// controller outputs: handshake and memory port
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = walk_addr_q;
		mem_we   = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				s_tready = 1'b1;
				// fetch the slot about to be overwritten
				rd_en    = s_tvalid && is_good;
				rd_addr  = next_slot;
			end
			FS_SAMPLE: mem_we = 1'b1;
			FS_WALK:   rd_en  = (issue_left_q != '0);
			FS_DIV:    rd_en  = 1'b0;
			FS_FINISH: rd_en  = 1'b0;
			default:   rd_en  = 1'b0;
		endcase
	end

	// sample store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_q] <= value_q;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// counter history, status and window length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q     <= ST_INITIALIZED;
			window_q     <= WIN_BITS'(WIN_RST);
			fill_q       <= '0;
			newest_q     <= '0;
			newest_vld_q <= 1'b0;
			sum_q        <= '0;
		end else if (cfg_wr_en) begin
			// re-create the counter
			window_q     <= cfg_clamped;
			status_q     <= ST_INITIALIZED;
			fill_q       <= '0;
			newest_q     <= '0;
			newest_vld_q <= 1'b0;
			sum_q        <= '0;
		end else if (state_q == FS_IDLE && accept) begin
			unique case (action_t'(in_action))
				ACT_GOOD_SAMPLE: begin
					if (supported) begin
						status_q <= ST_ACTIVE;
						sum_q    <= sum_q + {{(SUM_BITS-VALUE_BITS){in_value[VALUE_BITS-1]}},
							in_value};
					end
				end
				ACT_NEEDS_SECOND: begin
					if (supported) begin
						status_q <= ST_NEEDS_SECOND;
					end
				end
				ACT_FAILED: begin
					if (supported) begin
						status_q     <= ST_NOT_SUPPORTED;
						fill_q       <= '0;
						newest_q     <= '0;
						newest_vld_q <= 1'b0;
						sum_q        <= '0;
					end
				end
				ACT_REATTACH: begin
					if (!supported) begin
						status_q <= ST_INITIALIZED;
					end
				end
				default: begin
					// queries and unknown actions leave the history alone
				end
			endcase
		end else if (state_q == FS_SAMPLE) begin
			// old value leaves the sum once the window is full
			if (fill_q >= window_q) begin
				sum_q <= sum_q - {{(SUM_BITS-VALUE_BITS){rd_data_s1[VALUE_BITS-1]}},
					rd_data_s1};
			end else begin
				fill_q <= fill_q + WIN_BITS'(1);
			end
			newest_q     <= slot_q;
			newest_vld_q <= 1'b1;
		end
	end

	// item registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && accept) begin
			slot_q  <= next_slot;
			value_q <= in_value;
			ans_q   <= (action_t'(in_action) == ACT_QUERY) && (query_full || query_walk);
		end
	end

	// walk backwards from the newest slot, one read a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1    <= 1'b0;
			issue_left_q <= '0;
		end else begin
			rd_vld_s1 <= (state_q == FS_WALK) && rd_en;
			if (state_q == FS_IDLE && accept) begin
				issue_left_q <= query_walk ? walk_count : '0;
			end else if (state_q == FS_WALK && rd_en) begin
				issue_left_q <= issue_left_q - WIN_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && accept) begin
			walk_addr_q <= newest_q;
			acc_q       <= '0;
		end else if (state_q == FS_WALK) begin
			if (rd_en) begin
				if (walk_addr_q == '0) begin
					walk_addr_q <= ADDR_BITS'(window_q - WIN_BITS'(1));
				end else begin
					walk_addr_q <= walk_addr_q - ADDR_BITS'(1);
				end
			end
			if (rd_vld_s1) begin
				acc_q <= acc_q + {{(SUM_BITS-VALUE_BITS){rd_data_s1[VALUE_BITS-1]}},
					rd_data_s1};
			end
		end
	end

	// sample count of the walk, kept for the divisor
	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && accept) begin
			walk_count_q <= walk_count;
		end
	end

	// restoring divider on magnitudes, one quotient bit a cycle
	logic [WIN_BITS:0] div_trial;
	logic [WIN_BITS:0] div_diff;

	assign div_trial = {rem_q, dvd_q[SUM_BITS-1]};
	assign div_diff  = div_trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if ((state_q == FS_IDLE && accept && query_full) ||
				(state_q == FS_WALK && state_nx == FS_DIV)) begin
			div_cnt_q <= DCNT_W'(SUM_BITS);
		end else if (state_q == FS_DIV) begin
			div_cnt_q <= div_cnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && accept && query_full) begin
			// full window: running sum over the fill count
			neg_q <= sum_q[SUM_BITS-1];
			dvd_q <= sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);
			dvs_q <= fill_q;
			rem_q <= '0;
		end else if (state_q == FS_WALK && state_nx == FS_DIV) begin
			neg_q <= acc_q[SUM_BITS-1];
			dvd_q <= acc_q[SUM_BITS-1] ? SUM_BITS'(-acc_q) : SUM_BITS'(acc_q);
			dvs_q <= WIN_BITS'(walk_count_q);
			rem_q <= '0;
		end else if (state_q == FS_DIV) begin
			if (div_trial >= {1'b0, dvs_q}) begin
				rem_q <= div_diff[WIN_BITS-1:0];
				dvd_q <= {dvd_q[SUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= div_trial[WIN_BITS-1:0];
				dvd_q <= {dvd_q[SUM_BITS-2:0], 1'b0};
			end
		end
	end

	// result: signed quotient truncated toward zero, zero when unanswered
	logic [SUM_BITS-1:0]   quo_signed;
	logic [VALUE_BITS-1:0] avg_out;

	assign quo_signed = neg_q ? (~dvd_q + SUM_BITS'(1)) : dvd_q;
	assign avg_out    = ans_q ? quo_signed[VALUE_BITS-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == FS_FINISH && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_FINISH && out_free) begin
			m_tdata_q <= OUT_W'({ans_q, STATUS_BITS'(status_q), avg_out});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

>>> test/sliding_window_average_test.sv
// sliding_window_average_test: self-checking bench for the sliding window average block
// drives sample, status and query transfers with random gaps and checks every result
// depends on swa_pkg and the sliding_window_average rtl
`timescale 1ns / 100ps

module sliding_window_average_test
	import swa_pkg::*;
();

	localparam int VB    = VALUE_BITS_DEF;
	localparam int IN_W  = ((ACTION_BITS + VB + QWIN_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((VB + STATUS_BITS + 1 + 7) / 8) * 8;
	localparam int IDLE_LIMIT = 6000;

	// action codes the block does not know, they only report status
	localparam logic [ACTION_BITS-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [ACTION_BITS-1:0] ACT_SPARE_LAST  = 3'd7;

	localparam logic signed [VB-1:0] VAL_MAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] VAL_MIN = {1'b1, {(VB-1){1'b0}}};
	localparam logic signed [VB-1:0] VAL_MINUS_ONE = '1;
	// 900.0 in 16-bit fraction fixed point
	localparam logic signed [VB-1:0] VAL_900 = 48'sd58982400;

	typedef struct {
		logic signed [VB-1:0] average;
		status_t              status;
		logic                 answered;
	} window_result_t;

	typedef struct {
		logic [ACTION_BITS-1:0] action;
		logic [VB-1:0]          value;
		logic [QWIN_BITS-1:0]   qwin;
		bit                     typed;
		window_result_t         result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_wr_en = 1'b0;
	logic [CFG_BITS-1:0] cfg_wr_data = '0;

	sliding_window_average dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #4 clk = ~clk;

	// shadow of the counter: circular history, running sum, fill count, status
	longint  hist_store [MAX_WINDOW_DEF];
	int      hist_newest = 0;
	bit      hist_has_newest = 1'b0;
	longint  hist_sum = 0;
	int      hist_fill = 0;
	status_t hist_status = ST_INITIALIZED;
	int      hist_window = (WINDOW_RESET > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : WINDOW_RESET;

	window_result_t expected_results [$];
	stim_row_t      directed_rows [$];

	bit quiet = 1'b0;
	int fail_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int answered_count = 0;
	int settings_done = 1;

	function automatic void clear_history();
		hist_newest = 0;
		hist_has_newest = 1'b0;
		hist_sum = 0;
		hist_fill = 0;
	endfunction

	// register write re-creates the counter, out of range lengths are clamped
	function automatic void apply_window(logic [CFG_BITS-1:0] v);
		int len;
		len = int'(v);
		if (len < 1) begin
			len = 1;
		end
		if (len > MAX_WINDOW_DEF) begin
			len = MAX_WINDOW_DEF;
		end
		hist_window = len;
		clear_history();
		hist_status = ST_INITIALIZED;
	endfunction

	function automatic window_result_t predict_average(logic [ACTION_BITS-1:0] act,
			logic [VB-1:0] val, logic [QWIN_BITS-1:0] qw);
		window_result_t r;
		bit supported;
		longint acc;
		int cnt, idx, slot, n;
		r.average = '0;
		r.answered = 1'b0;
		supported = (hist_status != ST_NOT_SUPPORTED);
		n = int'(qw);
		case (act)
			ACT_GOOD_SAMPLE: begin
				if (supported) begin
					slot = hist_has_newest ? (hist_newest + 1) % hist_window : 0;
					hist_status = ST_ACTIVE;
					hist_newest = slot;
					hist_has_newest = 1'b1;
					// full window: oldest value drops out of the sum
					if (hist_fill >= hist_window) begin
						hist_sum -= hist_store[slot];
					end
					hist_store[slot] = longint'($signed(val));
					hist_sum += hist_store[slot];
					if (hist_fill < hist_window) begin
						hist_fill++;
					end
				end
			end
			ACT_NEEDS_SECOND: begin
				if (supported) begin
					hist_status = ST_NEEDS_SECOND;
				end
			end
			ACT_FAILED: begin
				if (supported) begin
					clear_history();
					hist_status = ST_NOT_SUPPORTED;
				end
			end
			ACT_REATTACH: begin
				if (!supported) begin
					hist_status = ST_INITIALIZED;
				end
			end
			ACT_QUERY: begin
				if (hist_status == ST_ACTIVE && n <= hist_window) begin
					if (n == 0) begin
						if (hist_fill != 0) begin
							r.average = hist_sum / longint'(hist_fill);
							r.answered = 1'b1;
						end
					end else begin
						cnt = (hist_fill < n) ? hist_fill : n;
						if (cnt != 0) begin
							// walk back from the newest slot, wrapping at the window end
							acc = 0;
							idx = hist_newest;
							for (int j = 0; j < cnt; j++) begin
								acc += hist_store[idx];
								idx = (idx > 0) ? idx - 1 : hist_window - 1;
							end
							r.average = acc / longint'(cnt);
							r.answered = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.status = hist_status;
		return r;
	endfunction

	function automatic void add_row(logic [ACTION_BITS-1:0] act, logic [VB-1:0] val,
			logic [QWIN_BITS-1:0] qw, bit typed, logic [VB-1:0] avg, status_t st, bit ans);
		stim_row_t row;
		row.action = act;
		row.value = val;
		row.qwin = qw;
		row.typed = typed;
		row.result.average = avg;
		row.result.status = st;
		row.result.answered = ans;
		directed_rows.push_back(row);
	endfunction

	// a random action code outside the defined set
	function automatic logic [ACTION_BITS-1:0] spare_action();
		return ACTION_BITS'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
	endfunction

	// one input transfer; the shadow is updated once the transfer is taken
	task automatic send_item(logic [ACTION_BITS-1:0] act, logic [VB-1:0] val,
			logic [QWIN_BITS-1:0] qw, bit typed, window_result_t fixed);
		int gap;
		window_result_t pred;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({qw, val, act});
		do @(posedge clk); while (!s_tready);
		pred = predict_average(act, val, qw);
		if (typed) begin
			expected_results.push_back(fixed);
		end else begin
			expected_results.push_back(pred);
		end
		items_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register writes only with the block idle
	task automatic write_window(logic [CFG_BITS-1:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		apply_window(v);
		settings_done++;
	endtask

	// result side: random stall per result, then compare with the oldest expectation
	initial begin
		int stall;
		window_result_t want;
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: tdata %h", m_tdata);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (want.answered) begin
					answered_count++;
				end
				if (m_tdata[VB-1:0] !== want.average) begin
					$error("average: expected %0d, got %0d", want.average,
						$signed(m_tdata[VB-1:0]));
					fail_count++;
				end
				if (m_tdata[VB+STATUS_BITS-1:VB] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status,
						m_tdata[VB+STATUS_BITS-1:VB]);
					fail_count++;
				end
				if (m_tdata[VB+STATUS_BITS] !== want.answered) begin
					$error("answered: expected %0d, got %0d", want.answered,
						m_tdata[VB+STATUS_BITS]);
					fail_count++;
				end
			end
		end
	end

	// watchdog: too long without any transfer or register write
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [CFG_BITS-1:0] window_settings [8];
		logic [ACTION_BITS-1:0] act;
		logic [VB-1:0] val;
		logic [QWIN_BITS-1:0] qw;
		window_result_t none;
		int pick;

		// directed part at the reset window length of 60
		add_row(ACT_QUERY, '0, 11'd0, 1, '0, ST_INITIALIZED, 0);
		add_row(ACT_SPARE_FIRST, VAL_MAX, 11'd0, 1, '0, ST_INITIALIZED, 0);
		add_row(ACT_SPARE_LAST, VAL_MIN, 11'd2047, 1, '0, ST_INITIALIZED, 0);
		add_row(ACT_NEEDS_SECOND, '0, 11'd0, 1, '0, ST_NEEDS_SECOND, 0);
		// needs-second counter is not active, no answer
		add_row(ACT_QUERY, '0, 11'd0, 1, '0, ST_NEEDS_SECOND, 0);
		add_row(ACT_GOOD_SAMPLE, VAL_MAX, 11'd0, 1, '0, ST_ACTIVE, 0);
		add_row(ACT_GOOD_SAMPLE, VAL_MIN, 11'd0, 1, '0, ST_ACTIVE, 0);
		// (max + min) / 2 = -1 / 2, truncates to zero
		add_row(ACT_QUERY, '0, 11'd0, 1, '0, ST_ACTIVE, 1);
		add_row(ACT_QUERY, '0, 11'd1, 1, VAL_MIN, ST_ACTIVE, 1);
		// query window above the window length
		add_row(ACT_QUERY, '0, 11'd61, 1, '0, ST_ACTIVE, 0);
		// custom window larger than the fill count
		add_row(ACT_QUERY, '0, 11'd60, 0, '0, ST_ACTIVE, 0);
		add_row(ACT_GOOD_SAMPLE, VAL_MINUS_ONE, 11'd0, 0, '0, ST_ACTIVE, 0);
		add_row(ACT_QUERY, '0, 11'd3, 0, '0, ST_ACTIVE, 0);
		add_row(ACT_QUERY, '0, 11'd2047, 1, '0, ST_ACTIVE, 0);
		add_row(ACT_FAILED, '0, 11'd0, 1, '0, ST_NOT_SUPPORTED, 0);
		// samples are ignored while not supported
		add_row(ACT_GOOD_SAMPLE, 48'sd12345, 11'd0, 1, '0, ST_NOT_SUPPORTED, 0);
		add_row(ACT_NEEDS_SECOND, '0, 11'd0, 1, '0, ST_NOT_SUPPORTED, 0);
		add_row(ACT_FAILED, '0, 11'd0, 1, '0, ST_NOT_SUPPORTED, 0);
		add_row(ACT_QUERY, '0, 11'd0, 1, '0, ST_NOT_SUPPORTED, 0);
		add_row(ACT_REATTACH, '0, 11'd0, 1, '0, ST_INITIALIZED, 0);
		// reattach while supported changes nothing
		add_row(ACT_REATTACH, '0, 11'd0, 1, '0, ST_INITIALIZED, 0);
		add_row(ACT_QUERY, '0, 11'd0, 1, '0, ST_INITIALIZED, 0);
		// history was dropped by the failure, so one sample is the whole mean
		add_row(ACT_GOOD_SAMPLE, VAL_900, 11'd0, 1, '0, ST_ACTIVE, 0);
		add_row(ACT_QUERY, '0, 11'd0, 1, VAL_900, ST_ACTIVE, 1);
		add_row(ACT_SPARE_FIRST + 3'd1, '0, 11'd0, 1, '0, ST_ACTIVE, 0);

		// window settings: extremes, out of range writes that clamp, wrapping sizes
		window_settings[0] = 11'd1;
		window_settings[1] = 11'd0;
		window_settings[2] = 11'd2;
		window_settings[3] = 11'd7;
		window_settings[4] = 11'd2047;
		window_settings[5] = 11'd1024;
		window_settings[6] = 11'd16;
		window_settings[7] = 11'd60;

		none.average = '0;
		none.status = ST_INITIALIZED;
		none.answered = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			send_item(directed_rows[k].action, directed_rows[k].value, directed_rows[k].qwin,
				directed_rows[k].typed, directed_rows[k].result);
		end

		for (int ph = 0; ph < 8; ph++) begin
			write_window(window_settings[ph]);
			// some phases run with no gaps on either side
			quiet = (ph == 3) || ($urandom_range(0, 3) == 0);
			repeat (64) begin
				pick = $urandom_range(0, 99);
				val = '0;
				qw = '0;
				if (pick < 55) begin
					act = ACT_GOOD_SAMPLE;
					case ($urandom_range(0, 3))
						0: val = VB'({$urandom, $urandom});
						1: val = VB'($signed($urandom_range(0, 2097151)) - 1048576);
						2: val = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
						default: val = $urandom_range(0, 1) ? VAL_MINUS_ONE : VAL_900;
					endcase
				end else if (pick < 82) begin
					act = ACT_QUERY;
					val = VB'({$urandom, $urandom});
					case ($urandom_range(0, 9))
						0, 1: qw = '0;
						7: qw = QWIN_BITS'(hist_window);
						8: qw = QWIN_BITS'(hist_window + 1);
						9: qw = QWIN_BITS'($urandom_range(0, 2047));
						default: qw = QWIN_BITS'($urandom_range(1, hist_window));
					endcase
				end else if (pick < 87) begin
					act = ACT_NEEDS_SECOND;
				end else if (pick < 91) begin
					act = ACT_FAILED;
				end else if (pick < 96) begin
					act = ACT_REATTACH;
				end else begin
					act = spare_action();
					qw = QWIN_BITS'($urandom_range(0, 2047));
				end
				send_item(act, val, qw, 0, none);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			fail_count++;
		end
		$display("covered %0d transfers over %0d window settings, %0d results checked",
			items_sent, settings_done, results_checked);
		$display("%0d queries answered, %0d mismatches", answered_count, fail_count);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
